### hdl/periodic_task_tick_scheduler_top_assert.svh
// Assertion macros for the periodic task tick scheduler.
// Used by periodic_task_tick_scheduler_top; no other dependencies.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_TOP_ASSERT_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_TOP_ASSERT_SVH

// checked only outside reset
`define PTTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked in every cycle, reset included
`define PTTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/ptts_pkg.sv
// Package for the periodic task tick scheduler: sizes, command and status codes,
// and the token that walks the chain of slot cells. No dependencies.
`timescale 1ns / 1ps

package ptts_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SLOT_W     = 8;
  localparam int TIME_W     = 16;
  localparam int MASK_W     = 8;
  localparam int CMD_W      = 3;
  localparam int STAT_W     = 2;

  localparam logic [SLOT_W-1:0] SLOT_LIMIT = SLOT_W'(SLOT_COUNT);

  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUSPEND = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RESUME  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_OCCUPIED   = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_HANDLER = 2'd2;
  localparam logic [STAT_W-1:0] ST_INVALID    = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] first_delay;
    logic              has_handler;
    logic [STAT_W-1:0] status;
    logic [MASK_W-1:0] fire_mask;
  } tok_t;

endpackage

### hdl/periodic_task_tick_scheduler_top.sv
// Top level of the periodic task tick scheduler: entry checks and a chain of
// SLOT_COUNT ptts_cell stages. Uses ptts_pkg, ptts_cell and the assertion header.
//
//   channel | dir | handshake         | payload
//   in_     | in  | in_tvalid/tready  | tuser: cmd; tdata: slot, period, first_delay, has_handler
//   out_    | out | out_tvalid/tready | tdata: status, fire_mask
//
// An item walks one cell per cycle while nothing downstream stalls: it is registered in
// each cell of the chain in turn, from the first cell to the last, before out_tvalid rises.
// Items follow each other down the chain, so one item can enter per cycle while out_tready
// is high. The last cell's register is the output register; a stall there backs up cell
// by cell. Synchronous reset clears all slots.
`timescale 1ns / 1ps

module periodic_task_tick_scheduler_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // slot[7:0], period[23:8], first_delay[39:24],
                                 // has_handler[40], zero[47:41]
  input  logic [2:0]  in_tuser,  // cmd[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata  // status[1:0], fire_mask[9:2], zero[15:10]
);

  logic                        vld [0:ptts_pkg::SLOT_COUNT];
  logic                        rdy [0:ptts_pkg::SLOT_COUNT];
  ptts_pkg::tok_t              tok [0:ptts_pkg::SLOT_COUNT];
  logic                        in_range;
  logic                        slot_cmd;
  logic [ptts_pkg::STAT_W-1:0] entry_status;

  assign in_range = in_tdata[7:0] < ptts_pkg::SLOT_LIMIT;
  assign slot_cmd = (in_tuser == ptts_pkg::CMD_CREATE) ||
                    (in_tuser == ptts_pkg::CMD_SUSPEND) ||
                    (in_tuser == ptts_pkg::CMD_RESUME) || (in_tuser == ptts_pkg::CMD_DELETE);

  always_comb begin
    entry_status = ptts_pkg::ST_OK;
    if (slot_cmd && !in_range) begin
      entry_status = ptts_pkg::ST_INVALID;
    end else if (in_tuser == ptts_pkg::CMD_CREATE && !in_tdata[40]) begin
      entry_status = ptts_pkg::ST_NO_HANDLER;
    end
  end

  always_comb begin
    tok[0].cmd         = in_tuser;
    tok[0].slot        = in_tdata[7:0];
    tok[0].period      = in_tdata[23:8];
    tok[0].first_delay = in_tdata[39:24];
    tok[0].has_handler = in_tdata[40];
    tok[0].status      = entry_status;
    tok[0].fire_mask   = '0;
  end

  assign vld[0]                   = in_tvalid;
  assign in_tready                = rdy[0];
  assign rdy[ptts_pkg::SLOT_COUNT] = out_tready;
  assign out_tvalid               = vld[ptts_pkg::SLOT_COUNT];
  assign out_tdata = {6'd0, tok[ptts_pkg::SLOT_COUNT].fire_mask,
                      tok[ptts_pkg::SLOT_COUNT].status};

  for (genvar i = 0; i < ptts_pkg::SLOT_COUNT; i++) begin : g_cell
    ptts_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (ptts_pkg::IDX_W'(i)),
      .up_valid (vld[i]),
      .up_tok   (tok[i]),
      .up_ready (rdy[i]),
      .dn_valid (vld[i+1]),
      .dn_tok   (tok[i+1]),
      .dn_ready (rdy[i+1])
    );
  end

`include "periodic_task_tick_scheduler_top_assert.svh"

  `PTTS_ASSERT_ALWAYS(a_out_idle_after_reset, !rst_n |=> !out_tvalid, "out_tvalid after reset")
  `PTTS_ASSERT(a_fire_only_ok,
    out_tvalid && out_tdata[9:2] != 8'd0 |-> out_tdata[1:0] == ptts_pkg::ST_OK,
    "fire_mask with bad status")
  `PTTS_ASSERT(a_invalid_out_of_range,
    vld[1] && tok[1].status == ptts_pkg::ST_INVALID |-> tok[1].slot >= ptts_pkg::SLOT_LIMIT,
    "invalid status on a valid slot")

endmodule

### hdl/ptts_cell.sv
// One slot cell of the scheduler chain: holds a slot's period, counter and flags,
// applies the passing token to them and registers the token for the next cell. Uses ptts_pkg.
`timescale 1ns / 1ps

module ptts_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [ptts_pkg::IDX_W-1:0] cell_idx,
  input  logic                       up_valid,
  input  ptts_pkg::tok_t             up_tok,
  output logic                       up_ready,
  output logic                       dn_valid,
  output ptts_pkg::tok_t             dn_tok,
  input  logic                       dn_ready
);

  logic [ptts_pkg::TIME_W-1:0] per_r, per_nxt;
  logic [ptts_pkg::TIME_W-1:0] cnt_r, cnt_nxt;
  logic                        rdy_r, rdy_nxt;
  logic                        occ_r, occ_nxt;
  logic                        vld_r, vld_nxt;
  ptts_pkg::tok_t              tok_r, tok_nxt;
  logic [ptts_pkg::SLOT_W-1:0] idx_ext;
  logic                        take;
  logic                        hit;

  assign idx_ext  = ptts_pkg::SLOT_W'(cell_idx);
  assign up_ready = !vld_r || dn_ready;
  assign take     = up_valid && up_ready;
  assign hit      = (up_tok.slot == idx_ext) && (up_tok.status == ptts_pkg::ST_OK);
  assign dn_valid = vld_r;
  assign dn_tok   = tok_r;

  always_comb begin
    per_nxt = per_r;
    cnt_nxt = cnt_r;
    rdy_nxt = rdy_r;
    occ_nxt = occ_r;
    tok_nxt = tok_r;
    vld_nxt = vld_r && !dn_ready;
    if (take) begin
      vld_nxt = 1'b1;
      tok_nxt = up_tok;
      case (up_tok.cmd)
        ptts_pkg::CMD_TICK: begin
          if (cnt_r == '0 && rdy_r) begin
            cnt_nxt = per_r - 16'd1;
            if (occ_r && idx_ext < ptts_pkg::SLOT_W'(ptts_pkg::MASK_W)) begin
              tok_nxt.fire_mask[idx_ext[2:0]] = 1'b1;
            end
          end else begin
            cnt_nxt = cnt_r - 16'd1;
          end
        end
        ptts_pkg::CMD_CREATE: begin
          if (hit) begin
            if (occ_r) begin
              tok_nxt.status = ptts_pkg::ST_OCCUPIED;
            end else begin
              per_nxt = up_tok.period;
              cnt_nxt = up_tok.first_delay;
              rdy_nxt = 1'b1;
              occ_nxt = 1'b1;
            end
          end
        end
        ptts_pkg::CMD_SUSPEND: begin
          if (hit) rdy_nxt = 1'b0;
        end
        ptts_pkg::CMD_RESUME: begin
          if (hit) rdy_nxt = 1'b1;
        end
        ptts_pkg::CMD_DELETE: begin
          if (hit) occ_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      per_r <= '0;
      cnt_r <= '0;
      rdy_r <= 1'b0;
      occ_r <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      per_r <= per_nxt;
      cnt_r <= cnt_nxt;
      rdy_r <= rdy_nxt;
      occ_r <= occ_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

endmodule

### tb/sv/periodic_task_tick_scheduler_checker.sv
// Checker for the periodic task tick scheduler: watches both stream channels, predicts
// each reply from its own copy of the slot table and compares. Uses ptts_pkg.
`timescale 1ns / 1ps

module periodic_task_tick_scheduler_checker
  import ptts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,  // slot[7:0], period[23:8], first_delay[39:24],
                                 // has_handler[40], zero[47:41]
  input  logic [2:0]  in_tuser,  // cmd[2:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata, // status[1:0], fire_mask[9:2], zero[15:10]
  output int          fail_count,
  output int          outstanding
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [MASK_W-1:0] fire_mask;
  } reply_t;

  localparam int PRINT_CAP = 40;

  logic [TIME_W-1:0] task_period    [SLOT_COUNT];
  logic [TIME_W-1:0] task_countdown [SLOT_COUNT];
  logic              task_ready     [SLOT_COUNT];
  logic              task_occupied  [SLOT_COUNT];

  reply_t expected_replies[$];
  reply_t want;

  // one scheduler step on the shadow slot table
  function automatic reply_t schedule_step(input logic [CMD_W-1:0] cmd,
                                           input logic [SLOT_W-1:0] slot,
                                           input logic [TIME_W-1:0] period,
                                           input logic [TIME_W-1:0] first_delay,
                                           input logic has_handler);
    reply_t r;
    logic   in_range;
    int     s;
    r        = '0;
    in_range = slot < SLOT_LIMIT;
    s        = in_range ? int'(slot) : 0;
    case (cmd)
      CMD_TICK: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (task_countdown[i] == '0 && task_ready[i]) begin
            if (task_occupied[i] && i < MASK_W) r.fire_mask[i] = 1'b1;
            task_countdown[i] = task_period[i] - 16'd1;
          end else begin
            task_countdown[i] = task_countdown[i] - 16'd1;
          end
        end
      end
      CMD_CREATE: begin
        if (!in_range) begin
          r.status = ST_INVALID;
        end else if (!has_handler) begin
          r.status = ST_NO_HANDLER;
        end else if (task_occupied[s]) begin
          r.status = ST_OCCUPIED;
        end else begin
          task_period[s]    = period;
          task_countdown[s] = first_delay;
          task_ready[s]     = 1'b1;
          task_occupied[s]  = 1'b1;
        end
      end
      CMD_SUSPEND: begin
        if (!in_range) r.status = ST_INVALID;
        else task_ready[s] = 1'b0;
      end
      CMD_RESUME: begin
        if (!in_range) r.status = ST_INVALID;
        else task_ready[s] = 1'b1;
      end
      CMD_DELETE: begin
        if (!in_range) r.status = ST_INVALID;
        else task_occupied[s] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    if (fail_count < PRINT_CAP)
      $display("%0t: %s: got %0h, want %0h", $realtime, what, got, exp_val);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        task_period[i]    = '0;
        task_countdown[i] = '0;
        task_ready[i]     = 1'b0;
        task_occupied[i]  = 1'b0;
      end
      expected_replies.delete();
      fail_count  = 0;
      outstanding <= 0;
    end else begin
      if (in_tvalid && in_tready)
        expected_replies.push_back(schedule_step(in_tuser, in_tdata[7:0], in_tdata[23:8],
                                                 in_tdata[39:24], in_tdata[40]));
      if (out_tvalid && out_tready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("result transfer with nothing expected", out_tdata, 0);
        end else begin
          want = expected_replies.pop_front();
          if (out_tdata[1:0] !== want.status)
            report_mismatch("status", out_tdata[1:0], want.status);
          if (out_tdata[9:2] !== want.fire_mask)
            report_mismatch("fire_mask", out_tdata[9:2], want.fire_mask);
          if (out_tdata[15:10] !== '0)
            report_mismatch("tdata padding", out_tdata[15:10], 0);
        end
      end
      outstanding <= expected_replies.size();
    end
  end

endmodule

### tb/sv/periodic_task_tick_scheduler_top_tb.sv
// Testbench top for the periodic task tick scheduler: clock, reset, directed and random
// command streams with random backpressure, watchdog and verdict.
// Uses ptts_pkg, periodic_task_tick_scheduler_top and periodic_task_tick_scheduler_checker.
`timescale 1ns / 1ps

module periodic_task_tick_scheduler_top_tb;
  import ptts_pkg::*;

  localparam int RANDOM_ITEMS = 1825;
  localparam int CALM_TAIL    = 250;
  localparam int STALL_LIMIT  = 1000;

  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = CMD_DELETE + 3'd1;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = '1;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // slot[7:0], period[23:8], first_delay[39:24],
                           // has_handler[40], zero[47:41]
  logic [2:0]  in_tuser;   // cmd[2:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // status[1:0], fire_mask[9:2], zero[15:10]

  int fail_count;
  int outstanding;
  int idle_level = 0;
  int quiet_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  periodic_task_tick_scheduler_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  periodic_task_tick_scheduler_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // result-side backpressure bursts
  initial begin
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (idle_level != 0 && $urandom_range(0, 7) < idle_level) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                           input logic [TIME_W-1:0] period,
                           input logic [TIME_W-1:0] first_delay, input logic has_handler);
    if (idle_level != 0 && $urandom_range(0, 7) < idle_level) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'b0, has_handler, first_delay, period, slot};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // hold off the sender until every reply has come back
  task automatic drain_replies();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic send_random_item();
    int                pick;
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] first_delay;
    logic              has_handler;
    pick        = $urandom_range(0, 99);
    slot        = ($urandom_range(0, 9) == 0) ? SLOT_W'($urandom_range(0, 255))
                                              : SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
    period      = ($urandom_range(0, 9) == 0) ? TIME_W'($urandom)
                                              : TIME_W'($urandom_range(0, 6));
    first_delay = ($urandom_range(0, 9) == 0) ? TIME_W'($urandom)
                                              : TIME_W'($urandom_range(0, 8));
    has_handler = ($urandom_range(0, 9) != 0);
    if (pick < 45) begin
      cmd = CMD_TICK;
    end else if (pick < 62) begin
      cmd = CMD_CREATE;
    end else if (pick < 72) begin
      cmd = CMD_SUSPEND;
    end else if (pick < 84) begin
      cmd = CMD_RESUME;
    end else if (pick < 95) begin
      cmd = CMD_DELETE;
    end else begin
      cmd         = CMD_W'($urandom_range(int'(CMD_UNUSED_FIRST), int'(CMD_UNUSED_LAST)));
      slot        = SLOT_W'($urandom);
      first_delay = TIME_W'($urandom);
      has_handler = 1'($urandom);
    end
    send_item(cmd, slot, period, first_delay, has_handler);
  endtask

  initial begin
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    rst_n     <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, create checks, field extremes
    send_item(CMD_TICK,    8'd0,   16'd0,     16'd0,     1'b0);
    send_item(CMD_CREATE,  8'd0,   16'd0,     16'd0,     1'b1);
    send_item(CMD_CREATE,  8'd0,   16'd5,     16'd5,     1'b1);
    send_item(CMD_CREATE,  8'd1,   16'd3,     16'd3,     1'b0);
    send_item(CMD_CREATE,  8'd8,   16'd3,     16'd3,     1'b1);
    send_item(CMD_CREATE,  8'd255, 16'hFFFF,  16'hFFFF,  1'b1);
    send_item(CMD_CREATE,  8'd7,   16'hFFFF,  16'd0,     1'b1);
    send_item(CMD_CREATE,  8'd3,   16'd1,     16'd2,     1'b1);
    send_item(CMD_TICK,    8'd0,   16'd0,     16'd0,     1'b0);
    send_item(CMD_TICK,    8'd0,   16'd0,     16'd0,     1'b0);
    send_item(CMD_TICK,    8'd0,   16'd0,     16'd0,     1'b0);
    // suspend and resume on a free slot and on an occupied one
    send_item(CMD_SUSPEND, 8'd5,   16'd0,     16'd0,     1'b0);
    send_item(CMD_RESUME,  8'd5,   16'd0,     16'd0,     1'b0);
    send_item(CMD_SUSPEND, 8'd3,   16'd0,     16'd0,     1'b0);
    send_item(CMD_TICK,    8'd0,   16'd0,     16'd0,     1'b0);
    send_item(CMD_RESUME,  8'd3,   16'd0,     16'd0,     1'b0);
    // deleted but ready slot keeps reloading silently
    send_item(CMD_DELETE,  8'd3,   16'd0,     16'd0,     1'b0);
    send_item(CMD_TICK,    8'd0,   16'd0,     16'd0,     1'b0);
    send_item(CMD_SUSPEND, 8'd200, 16'd0,     16'd0,     1'b0);
    send_item(CMD_RESUME,  8'd128, 16'd0,     16'd0,     1'b0);
    send_item(CMD_DELETE,  8'd255, 16'd0,     16'd0,     1'b0);
    send_item(CMD_UNUSED_FIRST,        8'hAA, 16'h5555, 16'hAAAA, 1'b1);
    send_item(CMD_UNUSED_FIRST + 3'd1, 8'h55, 16'hAAAA, 16'h5555, 1'b0);
    send_item(CMD_UNUSED_LAST,         8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_item(CMD_CREATE,  8'd6,   16'hFFFF,  16'hFFFF,  1'b1);
    drain_replies();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - CALM_TAIL) idle_level = 0;
      else if (n % 150 == 0) idle_level = $urandom_range(0, 3);
      if (n == RANDOM_ITEMS / 2) drain_replies();
      send_random_item();
    end
    drain_replies();
    repeat (2 * SLOT_COUNT) @(posedge clk);

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
